### sv/length_prefixed_record_parser_defines.svh
// Assertion macros shared by the record parser RTL.
`ifndef LENGTH_PREFIXED_RECORD_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPRP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lprp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPRP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lprp assertion failed");

`endif

### sv/lprp_pkg.sv
// Types, constants and helpers for the length-prefixed record parser.
`timescale 1ns / 1ps

package lprp_pkg;

    // Class of the next byte; the encoding is also the byte_class output code.
    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_DATE  = 3'd1,
        PH_COUNT = 3'd2,
        PH_FLAG  = 3'd3,
        PH_KLEN  = 3'd4,
        PH_KEY   = 3'd5,
        PH_VLEN  = 3'd6,
        PH_VAL   = 3'd7
    } phase_t;

    localparam int BYTE_W   = 8;
    localparam int NUM_W    = 64;
    localparam int REM_W    = 32;
    localparam int FIELD_W  = 31;
    localparam int POS_W    = 3;

    typedef struct packed {
        phase_t              phase;
        logic [POS_W-1:0]    byte_position;
        logic [NUM_W-1:0]    accumulator;
        logic [REM_W-1:0]    bytes_remaining;
        logic [FIELD_W-1:0]  fields_remaining;
        logic [FIELD_W-1:0]  field_index;
        logic [BYTE_W-1:0]   flag;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]          byte_class;
        logic [BYTE_W-1:0]   byte_out;
        logic                number_done;
        logic [NUM_W-1:0]    number_value;
        logic [BYTE_W-1:0]   current_flag;
        logic [FIELD_W-1:0]  field_number;
        logic                end_of_key;
        logic                end_of_field;
        logic                end_of_record;
    } parse_result_t;

    // Byte count of the number in each phase, modulo 8: the 8-byte date
    // completes when the 3-bit position wraps back to zero.
    function automatic logic [POS_W-1:0] num_len(input phase_t ph);
        logic [POS_W-1:0] len;
        case (ph)
            PH_HDR:   len = 3'd1;
            PH_DATE:  len = 3'd0;
            PH_COUNT: len = 3'd4;
            PH_FLAG:  len = 3'd1;
            PH_KLEN:  len = 3'd2;
            PH_VLEN:  len = 3'd4;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

### sv/lprp_step.sv
// Per-byte parse step: next parser state and the result for one byte.
`timescale 1ns / 1ps

module lprp_step (
    input  lprp_pkg::parse_state_t  state,
    input  logic [7:0]              data_byte,
    output lprp_pkg::parse_state_t  state_next,
    output lprp_pkg::parse_result_t result
);
    import lprp_pkg::*;

    phase_t             ph;
    logic               is_payload;
    logic [NUM_W-1:0]   acc_shift;
    logic [POS_W-1:0]   pos_inc;
    logic               num_complete;
    logic               rem_last;
    logic               field_last;
    logic               count_empty;
    logic               key_empty;
    logic               value_empty;
    logic               key_end;
    logic               field_end;
    logic               parsing_field;

    assign ph            = state.phase;
    assign is_payload    = (ph == PH_KEY) || (ph == PH_VAL);
    assign acc_shift     = {state.accumulator[NUM_W-BYTE_W-1:0], data_byte};
    assign pos_inc       = state.byte_position + 3'd1;
    assign num_complete  = !is_payload && (pos_inc == num_len(ph));
    assign rem_last      = (state.bytes_remaining <= 32'd1);
    assign field_last    = (state.fields_remaining <= 31'd1);
    // sign bit set means zero fields
    assign count_empty   = acc_shift[31] || (acc_shift[31:0] == 32'd0);
    assign key_empty     = (acc_shift[15:0] == 16'd0);
    assign value_empty   = (acc_shift[31:0] == 32'd0);
    assign key_end       = ((ph == PH_KEY) && rem_last)
                         || (num_complete && (ph == PH_KLEN) && key_empty);
    assign field_end     = ((ph == PH_VAL) && rem_last)
                         || (num_complete && (ph == PH_VLEN) && value_empty);
    assign parsing_field = (ph >= PH_FLAG);

    // next state
    always_comb
    begin
        state_next = state;
        if (is_payload)
        begin
            if (rem_last)
            begin
                state_next.bytes_remaining = '0;
                if (ph == PH_KEY)
                begin
                    state_next.phase = PH_VLEN;
                end
            end
            else
            begin
                state_next.bytes_remaining = state.bytes_remaining - 32'd1;
            end
        end
        else
        begin
            state_next.accumulator   = acc_shift;
            state_next.byte_position = pos_inc;
            if (num_complete)
            begin
                state_next.accumulator   = '0;
                state_next.byte_position = '0;
                case (ph)
                    PH_HDR:
                    begin
                        state_next.phase = PH_DATE;
                    end
                    PH_DATE:
                    begin
                        state_next.phase = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        if (!count_empty)
                        begin
                            state_next.fields_remaining = acc_shift[30:0];
                            state_next.field_index      = '0;
                            state_next.phase            = PH_FLAG;
                        end
                    end
                    PH_FLAG:
                    begin
                        state_next.flag  = data_byte;
                        state_next.phase = PH_KLEN;
                    end
                    PH_KLEN:
                    begin
                        if (key_empty)
                        begin
                            state_next.phase = PH_VLEN;
                        end
                        else
                        begin
                            state_next.bytes_remaining = {16'd0, acc_shift[15:0]};
                            state_next.phase           = PH_KEY;
                        end
                    end
                    PH_VLEN:
                    begin
                        if (!value_empty)
                        begin
                            state_next.bytes_remaining = acc_shift[31:0];
                            state_next.phase           = PH_VAL;
                        end
                    end
                    default:
                    begin
                        state_next.phase = ph;
                    end
                endcase
            end
        end

        // end of field: next field, or back to a field count after the last
        if (field_end)
        begin
            if (field_last)
            begin
                state_next.fields_remaining = '0;
                state_next.field_index      = '0;
                state_next.phase            = PH_COUNT;
            end
            else
            begin
                state_next.fields_remaining = state.fields_remaining - 31'd1;
                state_next.field_index      = state.field_index + 31'd1;
                state_next.phase            = PH_FLAG;
            end
        end
    end

    // result
    always_comb
    begin
        result.byte_class    = ph;
        result.byte_out      = data_byte;
        result.number_done   = num_complete;
        result.number_value  = num_complete ? acc_shift : '0;
        result.current_flag  = parsing_field ? state_next.flag : '0;
        result.field_number  = parsing_field ? state.field_index : '0;
        result.end_of_key    = key_end;
        result.end_of_field  = field_end;
        result.end_of_record = (field_end && field_last)
                             || (num_complete && (ph == PH_COUNT) && count_empty);
    end

endmodule

### sv/length_prefixed_record_parser.sv
// Top level of the length-prefixed record parser: input stage, parse state, result stage.
`timescale 1ns / 1ps
`include "length_prefixed_record_parser_defines.svh"

// Parses a byte stream (header flag, 8-byte date, then records of
// length-prefixed fields) and returns one result per byte: its class, the
// byte itself, completed big-endian numbers, and key, field and record ends.
// Throughput is one byte per clock unless result_ready stalls the output. A byte waits in
// the input register until the step fires, which is held while the result register
// holds an untaken result; the step loads the result register and raises result_valid.
// The rate is set by the parse-state register, updated once per byte by the combinational
// step logic between the input and result registers. There is no end-of-stream detection:
// after the last field of a record the parser expects another field count.
module length_prefixed_record_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         data_valid,
    output logic         data_ready,
    input  logic [7:0]   data_byte,
    output logic         result_valid,
    input  logic         result_ready,
    output logic [2:0]   byte_class,
    output logic [7:0]   byte_out,
    output logic         number_done,
    output logic [63:0]  number_value,
    output logic [7:0]   current_flag,
    output logic [30:0]  field_number,
    output logic         end_of_key,
    output logic         end_of_field,
    output logic         end_of_record
);
    import lprp_pkg::*;

    logic           in_valid_reg;
    logic           in_valid_next;
    logic [7:0]     in_byte_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    parse_result_t  out_reg;
    parse_state_t   state_reg;
    parse_state_t   state_next;
    parse_result_t  step_res;
    logic           out_free;
    logic           step_fire;
    logic           data_fire;
    logic           field_next_fire;
    logic           record_end_fire;
    logic           out_key_class;
    logic           out_payload_class;

    assign out_free   = !out_valid_reg || result_ready;
    assign step_fire  = in_valid_reg && out_free;
    assign data_ready = !in_valid_reg || step_fire;
    assign data_fire  = data_valid && data_ready;

    assign in_valid_next  = data_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_fire ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    lprp_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            state_reg.phase            <= PH_HDR;
            state_reg.byte_position    <= '0;
            state_reg.accumulator      <= '0;
            state_reg.bytes_remaining  <= '0;
            state_reg.fields_remaining <= '0;
            state_reg.field_index      <= '0;
            state_reg.flag             <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (data_fire)
        begin
            in_byte_reg <= data_byte;
        end
        if (step_fire)
        begin
            out_reg <= step_res;
        end
    end

    assign result_valid  = out_valid_reg;
    assign byte_class    = out_reg.byte_class;
    assign byte_out      = out_reg.byte_out;
    assign number_done   = out_reg.number_done;
    assign number_value  = out_reg.number_value;
    assign current_flag  = out_reg.current_flag;
    assign field_number  = out_reg.field_number;
    assign end_of_key    = out_reg.end_of_key;
    assign end_of_field  = out_reg.end_of_field;
    assign end_of_record = out_reg.end_of_record;

    assign field_next_fire   = step_fire && step_res.end_of_field && !step_res.end_of_record;
    assign record_end_fire   = step_fire && step_res.end_of_record;
    assign out_key_class     = (byte_class == PH_KLEN) || (byte_class == PH_KEY);
    assign out_payload_class = (byte_class == PH_KEY) || (byte_class == PH_VAL);

    `LPRP_ASSERT_NEXT(a_field_to_flag, field_next_fire, state_reg.phase == PH_FLAG)
    `LPRP_ASSERT_NEXT(a_record_to_count, record_end_fire, state_reg.phase == PH_COUNT)
    `LPRP_ASSERT_IMP(a_key_end_class, result_valid && end_of_key, out_key_class)
    `LPRP_ASSERT_IMP(a_payload_no_number, result_valid && out_payload_class, !number_done)

endmodule

### dv/testbench.sv
// Self-checking testbench for the length-prefixed record parser.
`timescale 1ns / 1ps

module testbench;
    import lprp_pkg::*;

    localparam int ITEM_TARGET    = 800;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 40;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         data_valid;
    logic         data_ready;
    logic [7:0]   data_byte;
    logic         result_valid;
    logic         result_ready;
    logic [2:0]   byte_class;
    logic [7:0]   byte_out;
    logic         number_done;
    logic [63:0]  number_value;
    logic [7:0]   current_flag;
    logic [30:0]  field_number;
    logic         end_of_key;
    logic         end_of_field;
    logic         end_of_record;

    length_prefixed_record_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_ready    (data_ready),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .byte_class    (byte_class),
        .byte_out      (byte_out),
        .number_done   (number_done),
        .number_value  (number_value),
        .current_flag  (current_flag),
        .field_number  (field_number),
        .end_of_key    (end_of_key),
        .end_of_field  (end_of_field),
        .end_of_record (end_of_record)
    );

    // Parse-state shadow and queue of expected per-byte results.
    class record_scoreboard;
        parse_result_t    expected_q[$];
        int               mismatches;
        int               results_seen;
        phase_t           phase;
        int               bytes_taken;
        logic [63:0]      accumulator;
        logic [31:0]      bytes_remaining;
        logic [30:0]      fields_remaining;
        logic [30:0]      field_index;
        logic [7:0]       flag;

        function new();
            mismatches       = 0;
            results_seen     = 0;
            phase            = PH_HDR;
            bytes_taken      = 0;
            accumulator      = '0;
            bytes_remaining  = '0;
            fields_remaining = '0;
            field_index      = '0;
            flag             = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int number_bytes(phase_t ph);
            case (ph)
                PH_HDR, PH_FLAG:   return 1;
                PH_DATE:           return 8;
                PH_KLEN:           return 2;
                default:           return 4;
            endcase
        endfunction

        // Returns 1 when the field just closed was the last of its record.
        function bit close_field();
            if (fields_remaining <= 31'd1) begin
                fields_remaining = '0;
                field_index      = '0;
                phase            = PH_COUNT;
                return 1'b1;
            end
            fields_remaining = fields_remaining - 31'd1;
            field_index      = field_index + 31'd1;
            phase            = PH_FLAG;
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b);
            parse_result_t r;
            phase_t        ph;
            logic [63:0]   v;
            r = '0;
            ph = phase;
            r.byte_class = ph;
            r.byte_out   = b;
            if (ph >= PH_FLAG)
                r.field_number = field_index;
            if (ph == PH_KEY || ph == PH_VAL) begin
                if (bytes_remaining <= 32'd1) begin
                    bytes_remaining = '0;
                    if (ph == PH_KEY) begin
                        r.end_of_key = 1'b1;
                        phase = PH_VLEN;
                    end
                    else begin
                        r.end_of_field  = 1'b1;
                        r.end_of_record = close_field();
                    end
                end
                else begin
                    bytes_remaining = bytes_remaining - 32'd1;
                end
            end
            else begin
                accumulator = {accumulator[55:0], b};
                bytes_taken++;
                if (bytes_taken == number_bytes(ph)) begin
                    v = accumulator;
                    r.number_done  = 1'b1;
                    r.number_value = v;
                    accumulator    = '0;
                    bytes_taken    = 0;
                    case (ph)
                        PH_HDR:  phase = PH_DATE;
                        PH_DATE: phase = PH_COUNT;
                        PH_COUNT: begin
                            // bit 31 set reads as a negative count: no fields
                            if (v[31] || v[31:0] == 32'd0) begin
                                r.end_of_record = 1'b1;
                                phase = PH_COUNT;
                            end
                            else begin
                                fields_remaining = v[30:0];
                                field_index      = '0;
                                phase            = PH_FLAG;
                            end
                        end
                        PH_FLAG: begin
                            flag  = b;
                            phase = PH_KLEN;
                        end
                        PH_KLEN: begin
                            if (v[15:0] == 16'd0) begin
                                r.end_of_key = 1'b1;
                                phase = PH_VLEN;
                            end
                            else begin
                                bytes_remaining = {16'd0, v[15:0]};
                                phase = PH_KEY;
                            end
                        end
                        default: begin
                            if (v[31:0] == 32'd0) begin
                                r.end_of_field  = 1'b1;
                                r.end_of_record = close_field();
                            end
                            else begin
                                bytes_remaining = v[31:0];
                                phase = PH_VAL;
                            end
                        end
                    endcase
                end
            end
            if (ph >= PH_FLAG)
                r.current_flag = flag;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_REPORTS)
                $display("mismatch at result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(parse_result_t got);
            parse_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, byte %02h", got.byte_out));
                results_seen++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("byte_class", 64'(got.byte_class), 64'(want.byte_class));
            compare_field("byte_out", 64'(got.byte_out), 64'(want.byte_out));
            compare_field("number_done", 64'(got.number_done), 64'(want.number_done));
            compare_field("number_value", got.number_value, want.number_value);
            compare_field("current_flag", 64'(got.current_flag), 64'(want.current_flag));
            compare_field("field_number", 64'(got.field_number), 64'(want.field_number));
            compare_field("end_of_key", 64'(got.end_of_key), 64'(want.end_of_key));
            compare_field("end_of_field", 64'(got.end_of_field), 64'(want.end_of_field));
            compare_field("end_of_record", 64'(got.end_of_record),
                          64'(want.end_of_record));
            results_seen++;
        endtask
    endclass

    record_scoreboard sb = new();

    logic [7:0]     stream_q[$];
    int             bytes_sent = 0;
    int             idle_cycles = 0;
    bit             calm = 1'b0;
    bit             rx_hold_req = 1'b0;
    parse_result_t  observed;

    always #2 clk = ~clk;

    initial begin
        rst_n        = 1'b0;
        data_valid   = 1'b0;
        data_byte    = 8'h00;
        result_ready = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly short keys and values, now and then a few hundred bytes.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 4);
        if (r < 96)
            return $urandom_range(5, 24);
        return $urandom_range(200, 300);
    endfunction

    // Sample both channels in one process: inputs are noted before results are checked.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (data_valid && data_ready)
                sb.note_byte(data_byte);
            if (result_valid && result_ready) begin
                observed.byte_class    = byte_class;
                observed.byte_out      = byte_out;
                observed.number_done   = number_done;
                observed.number_value  = number_value;
                observed.current_flag  = current_flag;
                observed.field_number  = field_number;
                observed.end_of_key    = end_of_key;
                observed.end_of_field  = end_of_field;
                observed.end_of_record = end_of_record;
                sb.check_result(observed);
            end
            if ((data_valid && data_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : receiver
        int stall_left;
        int run_left;
        int hold_left;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else begin
                result_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end
                else begin
                    run_left   = $urandom_range(0, 30);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            data_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic put_number(input logic [63:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            stream_q.push_back(v[8*i +: 8]);
    endtask

    task automatic put_random_bytes(input int n);
        repeat (n)
            stream_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic flush_stream();
        while (stream_q.size() > 0)
            send_byte(stream_q.pop_front());
    endtask

    task automatic add_random_record();
        int pick;
        int count;
        int klen;
        int vlen;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            put_number(64'd0, 4);
        end
        else if (pick < 14) begin
            put_number({32'd0, 1'b1, 31'($urandom)}, 4);
        end
        else begin
            count = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(4, 9);
            put_number(64'(count), 4);
            repeat (count) begin
                put_random_bytes(1);
                klen = pick_length();
                put_number(64'(klen), 2);
                put_random_bytes(klen);
                vlen = pick_length();
                put_number(64'(vlen), 4);
                put_random_bytes(vlen);
            end
        end
    endtask

    task automatic pause_until_drained();
        data_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    initial begin : stimulus
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // header flag at its minimum, date at its maximum
        put_number(64'h00, 1);
        put_number(64'hFFFF_FFFF_FFFF_FFFF, 8);
        // empty record, then an all-ones count that reads as negative
        put_number(64'd0, 4);
        put_number(64'hFFFF_FFFF, 4);
        // one field: empty key, empty value, record closes on the same byte
        put_number(64'd1, 4);
        put_number(64'hFF, 1);
        put_number(64'd0, 2);
        put_number(64'd0, 4);
        flush_stream();

        while (bytes_sent < ITEM_TARGET) begin
            if (!hold_done && bytes_sent >= 250) begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            if (!drain_done && bytes_sent >= 450) begin
                pause_until_drained();
                drain_done = 1'b1;
            end
            calm = (bytes_sent >= 550 && bytes_sent < 650);
            add_random_record();
            flush_stream();
        end
        calm = 1'b0;

        // value length with bit 31 set: the rest of the stream is value bytes
        put_number(64'd1, 4);
        put_random_bytes(1);
        put_number(64'd0, 2);
        put_number(64'hFFFF_FFFF, 4);
        put_random_bytes(48);
        flush_stream();
        data_valid <= 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### length_prefixed_record_parser.f
+incdir+sv
sv/lprp_pkg.sv
sv/lprp_step.sv
sv/length_prefixed_record_parser.sv
dv/testbench.sv
